>>> src/uhmd_pkg.sv
// Shared constants, codes and types for the ultrasonic hysteresis motor drive.
// No dependencies; every other file of the block depends on this package.
package uhmd_pkg;

    // Fixed timing constants of the ranging cycle and PWM
    localparam int unsigned PWM_W        = 10;
    localparam logic [PWM_W-1:0] PWM_PERIOD = 10'd1000;
    localparam logic [7:0]  TRIGGER_TICKS = 8'd10;
    localparam logic [5:0]  TICKS_PER_CM  = 6'd58;

    // Field and state widths
    localparam int unsigned CM_W      = 10;
    localparam int unsigned TICK_W    = 16;
    localparam int unsigned PHASE_T_W = 17;
    localparam int unsigned DIST_W    = 11;
    localparam int unsigned FRAC_W    = 6;
    localparam logic [DIST_W-1:0] CM_MAX = 11'd2047;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UPPER_CM   = 3'd0,
        CFG_LOWER_CM   = 3'd1,
        CFG_TIMEOUT    = 3'd2,
        CFG_PAUSE      = 3'd3,
        CFG_DUTY       = 3'd4
    } t_cfg_idx;

    // Register reset values
    localparam logic [CM_W-1:0]   RST_UPPER_CM = 10'd25;
    localparam logic [CM_W-1:0]   RST_LOWER_CM = 10'd15;
    localparam logic [TICK_W-1:0] RST_TIMEOUT  = 16'd25000;
    localparam logic [TICK_W-1:0] RST_PAUSE    = 16'd50000;
    localparam logic [PWM_W-1:0]  RST_DUTY     = 10'd500;

    typedef struct packed {
        logic [CM_W-1:0]   upper_cm;
        logic [CM_W-1:0]   lower_cm;
        logic [TICK_W-1:0] echo_timeout_ticks;
        logic [TICK_W-1:0] pause_ticks;
        logic [PWM_W-1:0]  drive_duty_ticks;
    } t_cfg;

    typedef struct packed {
        logic              trigger_out;
        logic              motor_forward_on;
        logic              pwm_enable_out;
        logic              led_on;
        logic [DIST_W-1:0] distance_cm;
        logic              distance_valid;
        logic              echo_timed_out;
    } t_result;

    // Ranging cycle phases, one-hot
    typedef enum logic [3:0] {
        PH_TRIGGER = 4'b0001,
        PH_RISE    = 4'b0010,
        PH_MEASURE = 4'b0100,
        PH_PAUSE   = 4'b1000
    } t_phase;

endpackage

>>> src/uhmd_if.sv
// Valid/ready channel interfaces for the echo tick input, the result output
// and the configuration write port. Depends on uhmd_pkg for widths.
interface uhmd_in_if;
    logic valid;
    logic ready;
    logic echo_level;
    modport source (output valid, output echo_level, input ready);
    modport sink   (input valid, input echo_level, output ready);
endinterface

interface uhmd_out_if;
    logic                        valid;
    logic                        ready;
    logic                        trigger_out;
    logic                        motor_forward_on;
    logic                        pwm_enable_out;
    logic                        led_on;
    logic [uhmd_pkg::DIST_W-1:0] distance_cm;
    logic                        distance_valid;
    logic                        echo_timed_out;
    modport source (output valid, output trigger_out, output motor_forward_on,
                    output pwm_enable_out, output led_on, output distance_cm,
                    output distance_valid, output echo_timed_out, input ready);
    modport sink   (input valid, input trigger_out, input motor_forward_on,
                    input pwm_enable_out, input led_on, input distance_cm,
                    input distance_valid, input echo_timed_out, output ready);
endinterface

interface uhmd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [uhmd_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [uhmd_pkg::CFG_DATA_W-1:0] wdata;
    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

>>> src/uhmd_seq.sv
// Ranging sequencer: phase state, width/cm counters, hysteresis flag and PWM.
// Advances one tick per i_step; depends on uhmd_pkg.
module uhmd_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_echo,
    input  uhmd_pkg::t_cfg    i_cfg,
    output uhmd_pkg::t_result o_result
);
    import uhmd_pkg::*;

    t_phase                 r_phase, n_phase;
    logic [PHASE_T_W-1:0]   r_ticks, n_ticks;
    logic [DIST_W-1:0]      r_cm, n_cm;
    logic [FRAC_W-1:0]      r_frac, n_frac;
    logic                   r_drive, n_drive;
    logic [PWM_W-1:0]       r_pwm, n_pwm;

    logic [PHASE_T_W-1:0]   ticks_inc;
    logic [PHASE_T_W-1:0]   timeout_x;
    logic [TICK_W-1:0]      hi_thr, lo_thr;
    logic                   from_rise;
    logic [DIST_W-1:0]      cm_base, cm_cnt;
    logic [FRAC_W-1:0]      frac_base, frac_inc, frac_cnt;
    logic [PWM_W:0]         pwm_inc;
    logic                   trig, meas_ok, tmo;

    assign ticks_inc = r_ticks + PHASE_T_W'(1);
    assign timeout_x = {1'b0, i_cfg.echo_timeout_ticks};
    assign hi_thr    = TICK_W'(TICK_W'(i_cfg.upper_cm) * TICK_W'(TICKS_PER_CM));
    assign lo_thr    = TICK_W'(TICK_W'(i_cfg.lower_cm) * TICK_W'(TICKS_PER_CM));

    // Width tick: bump the divide-by-cm sub-counter, restart it at the echo rise
    assign from_rise = (r_phase == PH_RISE);
    assign cm_base   = from_rise ? '0 : r_cm;
    assign frac_base = from_rise ? '0 : r_frac;
    assign frac_inc  = frac_base + FRAC_W'(1);
    always_comb begin
        if (frac_inc >= TICKS_PER_CM) begin
            frac_cnt = '0;
            cm_cnt   = (cm_base < CM_MAX) ? DIST_W'(cm_base + DIST_W'(1)) : cm_base;
        end else begin
            frac_cnt = frac_inc;
            cm_cnt   = cm_base;
        end
    end

    // Phase sequencing for one tick
    always_comb begin
        n_phase = r_phase;
        n_ticks = r_ticks;
        n_cm    = r_cm;
        n_frac  = r_frac;
        n_drive = r_drive;
        trig    = 1'b0;
        meas_ok = 1'b0;
        tmo     = 1'b0;
        unique case (r_phase)
            PH_TRIGGER: begin
                trig = 1'b1;
                if (ticks_inc >= PHASE_T_W'(TRIGGER_TICKS)) begin
                    n_phase = PH_RISE;
                    n_ticks = '0;
                end else begin
                    n_ticks = ticks_inc;
                end
            end
            PH_RISE: begin
                if (!i_echo) begin
                    n_ticks = ticks_inc;
                    tmo     = (ticks_inc > timeout_x);
                end else begin
                    n_phase = PH_MEASURE;
                    n_ticks = PHASE_T_W'(1);
                    n_cm    = cm_cnt;
                    n_frac  = frac_cnt;
                    tmo     = (PHASE_T_W'(1) > timeout_x);
                end
            end
            PH_MEASURE: begin
                if (i_echo) begin
                    n_ticks = ticks_inc;
                    n_cm    = cm_cnt;
                    n_frac  = frac_cnt;
                    tmo     = (ticks_inc > timeout_x);
                end else begin
                    meas_ok = 1'b1;
                    if (r_ticks > {1'b0, hi_thr}) begin
                        n_drive = 1'b1;
                    end else if (r_ticks < {1'b0, lo_thr}) begin
                        n_drive = 1'b0;
                    end
                    n_phase = PH_PAUSE;
                    n_ticks = '0;
                end
            end
            default: begin
                // pause; also recovers from any illegal phase code
                if (ticks_inc >= {1'b0, i_cfg.pause_ticks}) begin
                    n_phase = PH_TRIGGER;
                    n_ticks = '0;
                end else begin
                    n_phase = PH_PAUSE;
                    n_ticks = ticks_inc;
                end
            end
        endcase
        // Timeout: stop the motor, drop the distance, go to pause
        if (tmo) begin
            n_drive = 1'b0;
            n_cm    = '0;
            n_frac  = '0;
            n_phase = PH_PAUSE;
            n_ticks = '0;
        end
    end

    // Free-running PWM phase
    assign pwm_inc = {1'b0, r_pwm} + (PWM_W+1)'(1);
    assign n_pwm   = (pwm_inc >= {1'b0, PWM_PERIOD}) ? '0 : pwm_inc[PWM_W-1:0];

    always_comb begin
        o_result.trigger_out      = trig;
        o_result.motor_forward_on = n_drive;
        o_result.pwm_enable_out   = n_drive && (r_pwm < i_cfg.drive_duty_ticks);
        o_result.led_on           = n_drive;
        o_result.distance_cm      = n_cm;
        o_result.distance_valid   = meas_ok;
        o_result.echo_timed_out   = tmo;
    end

    // Hold state between ticks, advance on each step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TRIGGER;
            r_ticks <= '0;
            r_cm    <= '0;
            r_frac  <= '0;
            r_drive <= 1'b0;
            r_pwm   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_ticks <= n_ticks;
            r_cm    <= n_cm;
            r_frac  <= n_frac;
            r_drive <= n_drive;
            r_pwm   <= n_pwm;
        end
    end

    // Checks
    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase))
        else $error("phase register not one-hot");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frac < TICKS_PER_CM)
        else $error("cm sub-counter out of range");

    a_tmo_to_pause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && tmo |=> r_phase == PH_PAUSE && r_ticks == '0 && !r_drive && r_cm == '0)
        else $error("timeout did not stop and enter pause");

    a_done_to_pause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && meas_ok |=> r_phase == PH_PAUSE && r_ticks == '0)
        else $error("completed measurement did not enter pause");

    a_trig_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_phase == PH_TRIGGER
            && r_ticks == PHASE_T_W'(TRIGGER_TICKS - 8'd1)
            |=> r_phase == PH_RISE && r_ticks == '0)
        else $error("trigger pulse length wrong");

endmodule

>>> src/ultrasonic_hysteresis_motor_drive_unit.sv
// Top level of the ultrasonic hysteresis motor drive: config registers,
// input and result registers around uhmd_seq. Depends on uhmd_pkg, uhmd_if.
//
// Usage:
//   i_in  carries one transaction per microsecond tick with the sampled echo
//         level. o_out returns exactly one result transaction per tick:
//         trigger level, motor/LED/PWM enable, running distance in cm and
//         the completion and timeout pulses.
//   i_cfg writes one of five registers (0 upper_cm, 1 lower_cm,
//         2 echo_timeout_ticks, 3 pause_ticks, 4 drive_duty_ticks); it is
//         always ready, and other indexes are ignored. Write only while idle.
//   Path: an accepted tick waits in the input register and is loaded into the
//         result register, from which it can be taken, once that register is free
//         (input register, then result register).
//   Throughput: one tick per clock while o_out.ready stays high; the sequencer
//         state updates together with the result register.
//   Stall: when o_out.ready is low the result register holds, the input
//         register fills, and i_in.ready drops once both are occupied.
//   Reset: i_rst_n (synchronous, active low) empties both registers, loads
//         the register reset values and restarts in the trigger phase.
module ultrasonic_hysteresis_motor_drive_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    uhmd_in_if.sink     i_in,
    uhmd_cfg_if.sink    i_cfg,
    uhmd_out_if.source  o_out
);
    import uhmd_pkg::*;

    t_cfg       r_cfg;
    logic       r_s1_valid;
    logic       r_s1_echo;
    logic       r_out_valid;
    t_result    r_out;
    t_result    seq_result;
    logic       out_free;
    logic       s1_advance;

    // Configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.upper_cm           <= RST_UPPER_CM;
            r_cfg.lower_cm           <= RST_LOWER_CM;
            r_cfg.echo_timeout_ticks <= RST_TIMEOUT;
            r_cfg.pause_ticks        <= RST_PAUSE;
            r_cfg.drive_duty_ticks   <= RST_DUTY;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.reg_index))
                CFG_UPPER_CM: r_cfg.upper_cm           <= i_cfg.wdata[CM_W-1:0];
                CFG_LOWER_CM: r_cfg.lower_cm           <= i_cfg.wdata[CM_W-1:0];
                CFG_TIMEOUT:  r_cfg.echo_timeout_ticks <= i_cfg.wdata[TICK_W-1:0];
                CFG_PAUSE:    r_cfg.pause_ticks        <= i_cfg.wdata[TICK_W-1:0];
                CFG_DUTY:     r_cfg.drive_duty_ticks   <= i_cfg.wdata[PWM_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage handshake: result register frees when taken, input stage advances
    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_advance = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_echo <= i_in.echo_level;
        end
    end

    uhmd_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s1_advance),
        .i_echo   (r_s1_echo),
        .i_cfg    (r_cfg),
        .o_result (seq_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out <= seq_result;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.trigger_out      = r_out.trigger_out;
    assign o_out.motor_forward_on = r_out.motor_forward_on;
    assign o_out.pwm_enable_out   = r_out.pwm_enable_out;
    assign o_out.led_on           = r_out.led_on;
    assign o_out.distance_cm      = r_out.distance_cm;
    assign o_out.distance_valid   = r_out.distance_valid;
    assign o_out.echo_timed_out   = r_out.echo_timed_out;

endmodule

>>> dv/ultrasonic_hysteresis_motor_drive_unit_tb.sv
// Testbench for the ultrasonic hysteresis motor drive: directed ranging cycles,
// then random cycles under idling and back-pressure, checked tick by tick.
// Depends on uhmd_pkg, the uhmd_*_if interfaces and the top level.
module ultrasonic_hysteresis_motor_drive_unit_tb;
    import uhmd_pkg::*;

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned RANDOM_TICKS_PER_PHASE = 100;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_IDX_W'(CFG_DUTY + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST = '1;

    logic clk;
    logic rst_n;

    uhmd_in_if  in_ch();
    uhmd_cfg_if cfg_ch();
    uhmd_out_if out_ch();

    ultrasonic_hysteresis_motor_drive_unit u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // Ranger state as seen by the predictor
    t_cfg                 ranger_cfg;
    t_phase               rng_phase;
    logic [PHASE_T_W-1:0] rng_ticks;
    logic [DIST_W-1:0]    cm_whole;
    logic [FRAC_W-1:0]    cm_frac;
    logic                 drive_on;
    logic [PWM_W-1:0]     pwm_count;

    t_result     pending_outputs[$];
    int unsigned tick_count;
    int unsigned checked_count;
    int unsigned error_count;
    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Count one echo-high tick into the width and the whole-cm sub-counter
    function automatic void count_echo_tick();
        rng_ticks++;
        if (cm_frac == TICKS_PER_CM - 1) begin
            cm_frac = '0;
            if (cm_whole != CM_MAX) cm_whole++;
        end else begin
            cm_frac++;
        end
    endfunction

    // Advance the ranger by one tick and return the outputs it shows
    function automatic t_result predict_tick_outputs(input logic echo);
        t_result          res;
        logic [PWM_W-1:0] pwm_now;
        logic             trig;
        logic             got_width;
        logic             tmo;
        trig = 1'b0;
        got_width = 1'b0;
        tmo = 1'b0;
        pwm_now = pwm_count;
        case (rng_phase)
            PH_TRIGGER: begin
                trig = 1'b1;
                rng_ticks++;
                if (rng_ticks >= TRIGGER_TICKS) begin
                    rng_phase = PH_RISE;
                    rng_ticks = '0;
                end
            end
            PH_RISE: begin
                if (!echo) begin
                    rng_ticks++;
                end else begin
                    rng_phase = PH_MEASURE;
                    rng_ticks = '0;
                    cm_whole = '0;
                    cm_frac = '0;
                    count_echo_tick();
                end
                tmo = (rng_ticks > ranger_cfg.echo_timeout_ticks);
            end
            PH_MEASURE: begin
                if (echo) begin
                    count_echo_tick();
                    tmo = (rng_ticks > ranger_cfg.echo_timeout_ticks);
                end else begin
                    // Upper threshold wins when the two are crossed
                    got_width = 1'b1;
                    if (32'(rng_ticks) > 32'(ranger_cfg.upper_cm) * 32'(TICKS_PER_CM))
                        drive_on = 1'b1;
                    else if (32'(rng_ticks) < 32'(ranger_cfg.lower_cm) * 32'(TICKS_PER_CM))
                        drive_on = 1'b0;
                    rng_phase = PH_PAUSE;
                    rng_ticks = '0;
                end
            end
            default: begin
                rng_ticks++;
                if (rng_ticks >= ranger_cfg.pause_ticks) begin
                    rng_phase = PH_TRIGGER;
                    rng_ticks = '0;
                end
            end
        endcase

        // A timeout stops the motor, drops the distance and starts the pause
        if (tmo) begin
            drive_on = 1'b0;
            cm_whole = '0;
            cm_frac = '0;
            rng_phase = PH_PAUSE;
            rng_ticks = '0;
        end

        pwm_count = (pwm_count == PWM_PERIOD - 1) ? '0 : pwm_count + 1'b1;

        res = '0;
        res.trigger_out = trig;
        res.motor_forward_on = drive_on;
        res.pwm_enable_out = drive_on && (pwm_now < ranger_cfg.drive_duty_ticks);
        res.led_on = drive_on;
        res.distance_cm = cm_whole;
        res.distance_valid = got_width;
        res.echo_timed_out = tmo;
        return res;
    endfunction

    // Send one echo tick, idling before it at random, and record its outputs
    task automatic send_tick(input logic echo);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.echo_level <= echo;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        pending_outputs.push_back(predict_tick_outputs(echo));
        tick_count++;
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic drain_outputs();
        in_ch.valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; bits above the register width carry junk
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        logic [CFG_DATA_W-1:0] wd;
        int unsigned           w;
        case (idx)
            CFG_TIMEOUT, CFG_PAUSE: w = TICK_W;
            CFG_UPPER_CM, CFG_LOWER_CM, CFG_DUTY: w = CM_W;
            default: w = 0;
        endcase
        wd = 16'($urandom() << w) | 16'(val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wdata <= wd;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        case (idx)
            CFG_UPPER_CM: ranger_cfg.upper_cm = wd[CM_W-1:0];
            CFG_LOWER_CM: ranger_cfg.lower_cm = wd[CM_W-1:0];
            CFG_TIMEOUT:  ranger_cfg.echo_timeout_ticks = wd[TICK_W-1:0];
            CFG_PAUSE:    ranger_cfg.pause_ticks = wd[TICK_W-1:0];
            CFG_DUTY:     ranger_cfg.drive_duty_ticks = wd[PWM_W-1:0];
            default: ;
        endcase
    endtask

    // Reload every register while idle, plus one write to a spare index
    task automatic load_config(input int unsigned upper, input int unsigned lower,
                               input int unsigned timeout, input int unsigned pause,
                               input int unsigned duty);
        drain_outputs();
        write_reg(CFG_UPPER_CM, upper);
        write_reg(CFG_LOWER_CM, lower);
        write_reg(CFG_TIMEOUT, timeout);
        write_reg(CFG_PAUSE, pause);
        write_reg(CFG_DUTY, duty);
        write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)), 0);
        cfg_ch.valid <= 1'b0;
    endtask

    // Run ticks until the ranger has passed its pause and is back at trigger
    task automatic run_cycle(input int unsigned rise_wait, input int unsigned width,
                             input bit noisy);
        logic echo;
        bit   seen_pause;
        seen_pause = 1'b0;
        while (!(seen_pause && rng_phase == PH_TRIGGER)) begin
            case (rng_phase)
                PH_RISE:    echo = (rng_ticks >= rise_wait);
                PH_MEASURE: echo = (rng_ticks < width);
                default:    echo = 1'($urandom());
            endcase
            if (noisy) echo = 1'($urandom());
            send_tick(echo);
            if (rng_phase == PH_PAUSE) seen_pause = 1'b1;
        end
    endtask

    // Run ticks until the ranger enters its pause, leaving the pause to a later setting
    task automatic run_to_pause(input int unsigned rise_wait, input int unsigned width);
        logic echo;
        while (rng_phase != PH_PAUSE) begin
            case (rng_phase)
                PH_RISE:    echo = (rng_ticks >= rise_wait);
                PH_MEASURE: echo = (rng_ticks < width);
                default:    echo = 1'($urandom());
            endcase
            send_tick(echo);
        end
    endtask

    // Reset register values: a short width below the lower threshold, then a
    // few ticks into the long pause
    task automatic test_reset_values();
        run_to_pause(4, 100);
        repeat (3) send_tick(1'($urandom()));
    endtask

    // Hysteresis band edges with equal thresholds, and crossed thresholds
    task automatic test_hysteresis();
        load_config(1, 1, 100, 0, 500);
        run_cycle(3, TICKS_PER_CM + 1, 1'b0);
        run_cycle(0, TICKS_PER_CM, 1'b0);
        run_cycle(0, TICKS_PER_CM - 1, 1'b0);
        run_cycle(0, TICKS_PER_CM, 1'b0);
        load_config(0, 1, 100, 2, 700);
        run_cycle(1, 1, 1'b0);
    endtask

    // Rise and width waits at and just past the timeout
    task automatic test_timeout_limits();
        load_config(0, 0, 20, 0, 300);
        run_cycle(2, 20, 1'b0);
        run_cycle(0, 21, 1'b0);
        run_cycle(20, 5, 1'b0);
        run_cycle(21, 5, 1'b0);
        load_config(0, 0, 1, 0, 300);
        run_cycle(1, 1, 1'b0);
        run_cycle(2, 1, 1'b0);
        run_cycle(0, 2, 1'b0);
    endtask

    // Largest thresholds, timeout and pause
    task automatic test_range_extremes();
        load_config(1023, 1023, 65535, 0, 500);
        run_cycle(0, 5, 1'b0);
        load_config(1023, 1023, 1, 65535, 1);
        run_to_pause(0, 1);
    endtask

    // Drive through pauses with the duty at zero, at the period and above
    task automatic test_pwm_duty();
        load_config(0, 0, 50, 60, 1023);
        run_cycle(0, 3, 1'b0);
        load_config(0, 0, 50, 60, 0);
        run_cycle(0, 3, 1'b0);
        load_config(0, 0, 50, 60, 1000);
        run_cycle(0, 3, 1'b0);
    endtask

    // Random cycles in four idling phases, with a fresh setting every few cycles
    task automatic test_random_ranging();
        int unsigned idle_src[4];
        int unsigned idle_sink[4];
        int unsigned first_tick;
        int unsigned cycles;
        int unsigned rise_wait;
        int unsigned width;
        int unsigned duty;
        int          thr;
        bit          noisy;
        idle_src = '{0, 68, 0, 28};
        idle_sink = '{0, 0, 68, 28};
        for (int p = 0; p < 4; p++) begin
            src_idle_pct = idle_src[p];
            sink_stall_pct = idle_sink[p];
            first_tick = tick_count;
            cycles = 0;
            while (tick_count - first_tick < RANDOM_TICKS_PER_PHASE) begin
                if (cycles % 2 == 0) begin
                    case ($urandom_range(0, 3))
                        0: duty = 0;
                        1: duty = PWM_PERIOD;
                        2: duty = 1023;
                        default: duty = $urandom_range(0, 1023);
                    endcase
                    load_config($urandom_range(0, 2), $urandom_range(0, 2),
                                ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4)
                                                            : $urandom_range(20, 120),
                                ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 30),
                                duty);
                end
                rise_wait = ($urandom_range(0, 9) == 0)
                          ? ranger_cfg.echo_timeout_ticks + $urandom_range(0, 1)
                          : $urandom_range(0, 6);
                thr = -1;
                case ($urandom_range(0, 9))
                    0: width = ranger_cfg.echo_timeout_ticks + $urandom_range(0, 1);
                    1, 2: thr = int'(ranger_cfg.upper_cm) * int'(TICKS_PER_CM);
                    3: thr = int'(ranger_cfg.lower_cm) * int'(TICKS_PER_CM);
                    default: width = $urandom_range(1, ranger_cfg.echo_timeout_ticks);
                endcase
                // Land one tick below, on, or above a threshold
                if (thr >= 0) begin
                    thr = thr - 1 + int'($urandom_range(0, 2));
                    width = (thr < 1) ? 1 : thr;
                end
                noisy = ($urandom_range(0, 7) == 0);
                run_cycle(rise_wait, width, noisy);
                cycles++;
            end
        end
        src_idle_pct = 0;
        sink_stall_pct = 0;
    endtask

    // Record one wrong field
    task automatic report_field(input string field, input logic [DIST_W-1:0] want,
                                input logic [DIST_W-1:0] got);
        error_count++;
        if (error_count <= 10)
            $display("result %0d %s: expected %0d, got %0d",
                     checked_count, field, want, got);
    endtask

    // Check each result transaction against the oldest expectation
    initial begin : result_check
        t_result want;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready) begin
                if (pending_outputs.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("result %0d arrived with none expected", checked_count);
                end else begin
                    want = pending_outputs.pop_front();
                    if (out_ch.trigger_out !== want.trigger_out)
                        report_field("trigger_out", DIST_W'(want.trigger_out),
                                     DIST_W'(out_ch.trigger_out));
                    if (out_ch.motor_forward_on !== want.motor_forward_on)
                        report_field("motor_forward_on", DIST_W'(want.motor_forward_on),
                                     DIST_W'(out_ch.motor_forward_on));
                    if (out_ch.pwm_enable_out !== want.pwm_enable_out)
                        report_field("pwm_enable_out", DIST_W'(want.pwm_enable_out),
                                     DIST_W'(out_ch.pwm_enable_out));
                    if (out_ch.led_on !== want.led_on)
                        report_field("led_on", DIST_W'(want.led_on), DIST_W'(out_ch.led_on));
                    if (out_ch.distance_cm !== want.distance_cm)
                        report_field("distance_cm", want.distance_cm, out_ch.distance_cm);
                    if (out_ch.distance_valid !== want.distance_valid)
                        report_field("distance_valid", DIST_W'(want.distance_valid),
                                     DIST_W'(out_ch.distance_valid));
                    if (out_ch.echo_timed_out !== want.echo_timed_out)
                        report_field("echo_timed_out", DIST_W'(want.echo_timed_out),
                                     DIST_W'(out_ch.echo_timed_out));
                end
                checked_count++;
            end
            out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // End the run when no transaction moves for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        // Hold inputs quiet and the predictor at its reset state
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.echo_level = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.reg_index = '0;
        cfg_ch.wdata = '0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        tick_count = 0;
        checked_count = 0;
        error_count = 0;
        ranger_cfg.upper_cm = RST_UPPER_CM;
        ranger_cfg.lower_cm = RST_LOWER_CM;
        ranger_cfg.echo_timeout_ticks = RST_TIMEOUT;
        ranger_cfg.pause_ticks = RST_PAUSE;
        ranger_cfg.drive_duty_ticks = RST_DUTY;
        rng_phase = PH_TRIGGER;
        rng_ticks = '0;
        cm_whole = '0;
        cm_frac = '0;
        drive_on = 1'b0;
        pwm_count = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_hysteresis();
        test_timeout_limits();
        test_range_extremes();
        test_pwm_duty();
        test_random_ranging();
        drain_outputs();

        if (error_count == 0 && pending_outputs.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
